### hw/rtl/assert_macros.svh
// Assertion helpers shared by the run-length histogram RTL.
// Both macros expect i_clk and i_rst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside of reset.
`define RLH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define RLH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rlh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlh_pkg
// Shared types, widths and helpers of the run-length histogram block.
// ----------------------------------------------------------------------------
package rlh_pkg;

    localparam int MAX_RUN_LEN  = 24;
    localparam int MAX_SEQ_BITS = 1048576;

    localparam int CFG_W      = 5;
    localparam int LEN_OUT_W  = 5;
    localparam int CNT_W      = $clog2(MAX_SEQ_BITS + 1);
    localparam int IDX_W      = $clog2(MAX_RUN_LEN);
    localparam int K_W        = $clog2(MAX_RUN_LEN + 1);
    localparam int LEN_W      = $clog2(MAX_RUN_LEN + 2);
    localparam int ADDR_W     = IDX_W + 1;
    localparam int HIST_DEPTH = 2 ** ADDR_W;

    localparam logic [CFG_W-1:0] K_RESET   = CFG_W'(10);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        S_RUN,
        S_FINAL,
        S_WAIT,
        S_DUMP
    } t_state;

    // A run that is to be counted: its bit value and its length minus one.
    typedef struct packed {
        logic             valid;
        logic             value;
        logic [IDX_W-1:0] idx;
    } t_cnt_req;

    // Read request to the histogram memory; incr marks a read-modify-write.
    typedef struct packed {
        logic              en;
        logic              incr;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    // Longest counted run as it takes effect: zero acts as one, and values
    // above MAX_RUN_LEN are clipped to it.
    function automatic logic [K_W-1:0] eff_k(input logic [CFG_W-1:0] cfg);
        logic [K_W-1:0] k;
        if (cfg == '0) begin
            k = K_W'(1);
        end else if (int'(cfg) > MAX_RUN_LEN) begin
            k = K_W'(MAX_RUN_LEN);
        end else begin
            k = K_W'(cfg);
        end
        return k;
    endfunction

endpackage

### hw/rtl/rlh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlh_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rlh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/rlh_tracker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rlh_tracker
// Follows the current run and reports the runs that end and are counted.
// ----------------------------------------------------------------------------
module rlh_tracker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic                     i_bit,
    input  logic                     i_clear,
    input  logic [rlh_pkg::K_W-1:0]  i_k,
    output rlh_pkg::t_cnt_req        o_end_req,
    output rlh_pkg::t_cnt_req        o_final_req
);

    logic                         r_prev;
    logic                         n_prev;
    logic                         r_have;
    logic                         n_have;
    logic [rlh_pkg::LEN_W-1:0]    r_len;
    logic [rlh_pkg::LEN_W-1:0]    n_len;
    logic [rlh_pkg::LEN_W-1:0]    k_len;
    logic [rlh_pkg::LEN_W-1:0]    k_plus;
    logic                         len_counted;

    assign k_len       = rlh_pkg::LEN_W'(i_k);
    assign k_plus      = k_len + 1'b1;
    assign len_counted = (r_len != '0) && (r_len <= k_len);

    always_comb begin
        n_prev = r_prev;
        n_have = r_have;
        n_len  = r_len;
        if (i_clear) begin
            n_prev = 1'b0;
            n_have = 1'b0;
            n_len  = '0;
        end else if (i_accept) begin
            if (!r_have) begin
                n_prev = i_bit;
                n_have = 1'b1;
                n_len  = rlh_pkg::LEN_W'(1);
            end else if (i_bit == r_prev) begin
                // The counter stops one past k, so an over-long run never counts.
                n_len = (r_len < k_plus) ? r_len + 1'b1 : k_plus;
            end else begin
                n_prev = i_bit;
                n_len  = rlh_pkg::LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 1'b0;
            r_have <= 1'b0;
            r_len  <= '0;
        end else begin
            r_prev <= n_prev;
            r_have <= n_have;
            r_len  <= n_len;
        end
    end

    always_comb begin
        o_end_req.valid   = i_accept && r_have && (i_bit != r_prev) && len_counted;
        o_end_req.value   = r_prev;
        o_end_req.idx     = rlh_pkg::IDX_W'(r_len - 1'b1);
        o_final_req.valid = r_have && len_counted;
        o_final_req.value = r_prev;
        o_final_req.idx   = rlh_pkg::IDX_W'(r_len - 1'b1);
    end

    `RLH_ASSERT(a_have_len, (r_have == (r_len != '0)), "run length and run presence disagree")
    `RLH_ASSERT_IMPL(a_end_idx, o_end_req.valid, (r_len <= k_len), "counted run exceeds k")

endmodule

### hw/rtl/rlh_hist.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rlh_hist
// Histogram memory with per-entry valid bits and an increment write stage.
// ----------------------------------------------------------------------------
module rlh_hist (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rlh_pkg::t_rd_req          i_rd,
    input  logic                      i_clear,
    output logic [rlh_pkg::CNT_W-1:0] o_count
);

    logic [rlh_pkg::HIST_DEPTH-1:0] r_vbits;
    logic                           r_rd_vbit;
    logic                           r_wr_pend;
    logic [rlh_pkg::ADDR_W-1:0]     r_wr_addr;
    logic [rlh_pkg::CNT_W-1:0]      ram_rdata;
    logic [rlh_pkg::CNT_W-1:0]      cur_count;
    logic [rlh_pkg::CNT_W-1:0]      wr_data;

    rlh_ram #(
        .WIDTH (rlh_pkg::CNT_W),
        .DEPTH (rlh_pkg::HIST_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_wr_pend),
        .i_waddr (r_wr_addr),
        .i_wdata (wr_data),
        .i_re    (i_rd.en),
        .i_raddr (i_rd.addr),
        .o_rdata (ram_rdata)
    );

    // An entry never written since the last clear reads as zero.
    assign cur_count = r_rd_vbit ? ram_rdata : '0;
    assign wr_data   = (cur_count == rlh_pkg::CNT_MAX) ? cur_count : cur_count + 1'b1;
    assign o_count   = cur_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbits   <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            if (i_clear) begin
                r_vbits <= '0;
            end else if (r_wr_pend) begin
                r_vbits[r_wr_addr] <= 1'b1;
            end
            r_wr_pend <= i_rd.en && i_rd.incr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_wr_addr <= i_rd.addr;
            r_rd_vbit <= r_vbits[i_rd.addr];
        end
    end

    // Back-to-back run ends alternate in bit value, so a read never hits the
    // entry whose write is still in flight.
    `RLH_ASSERT_IMPL(a_no_rmw_overlap, (i_rd.en && r_wr_pend), (i_rd.addr != r_wr_addr),
                     "read collides with pending write")

endmodule

### hw/rtl/run_length_histogram_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// run_length_histogram_core
// Run-length histogram of a bit stream, dumped at the end of each sequence.
// ----------------------------------------------------------------------------
// Takes one bit per cycle while a sequence streams in; each run end is one
// read-modify-write increment on the histogram memory (registered read, write
// in the following cycle), and successive run ends always touch different
// entries, so the stream never stalls. After the word marked end of sequence
// the input stays stalled: the block counts the last run (read, then write
// back), reads the first entry, and then sends 2k histogram words, ones runs
// first, one per cycle when the output is not stalled. It takes new input the
// cycle after the last word is taken.
// The histogram clears through per-entry valid bits, so there is no clearing
// pass after reset or after a dump.
module run_length_histogram_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rlh_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_bit_in,
    input  logic                          i_end_of_sequence,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_run_value,
    output logic [rlh_pkg::LEN_OUT_W-1:0] o_run_length,
    output logic [rlh_pkg::CNT_W-1:0]     o_run_count,
    output logic                          o_last_entry
);

    rlh_pkg::t_state               r_state;
    rlh_pkg::t_state               n_state;
    logic [rlh_pkg::CFG_W-1:0]     r_k_cfg;
    logic [rlh_pkg::K_W-1:0]       k;
    logic                          accept;
    logic                          pop;
    logic                          done;
    logic                          dump_issue;
    logic                          dump_at_end;
    logic                          stall_int;
    rlh_pkg::t_cnt_req             end_req;
    rlh_pkg::t_cnt_req             final_req;
    rlh_pkg::t_rd_req              rd_req;
    logic                          r_dump_val;
    logic [rlh_pkg::IDX_W-1:0]     r_dump_idx;
    logic                          r_dump_more;
    logic [rlh_pkg::IDX_W:0]       dump_len;
    logic                          r_out_valid;
    logic                          r_out_value;
    logic [rlh_pkg::LEN_OUT_W-1:0] r_out_len;
    logic                          r_out_last;

    assign k           = rlh_pkg::eff_k(r_k_cfg);
    assign accept      = i_valid && !stall_int;
    assign pop         = r_out_valid && !i_stall;
    assign done        = (r_state == rlh_pkg::S_DUMP) && pop && r_out_last;
    assign dump_issue  = (r_state == rlh_pkg::S_DUMP) && r_dump_more && (!r_out_valid || pop);
    assign dump_at_end = (r_dump_idx == rlh_pkg::IDX_W'(k - 1'b1));
    assign dump_len    = {1'b0, r_dump_idx} + 1'b1;

    rlh_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_bit       (i_bit_in),
        .i_clear     (done),
        .i_k         (k),
        .o_end_req   (end_req),
        .o_final_req (final_req)
    );

    rlh_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd_req),
        .i_clear (done),
        .o_count (o_run_count)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rlh_pkg::S_RUN: begin
                if (accept && i_end_of_sequence) begin
                    n_state = rlh_pkg::S_FINAL;
                end
            end
            rlh_pkg::S_FINAL: n_state = rlh_pkg::S_WAIT;
            rlh_pkg::S_WAIT:  n_state = rlh_pkg::S_DUMP;
            rlh_pkg::S_DUMP: begin
                if (done) begin
                    n_state = rlh_pkg::S_RUN;
                end
            end
        endcase
    end

    // State outputs: input stall and the memory read request.
    always_comb begin
        stall_int   = 1'b1;
        rd_req.en   = 1'b0;
        rd_req.incr = 1'b1;
        rd_req.addr = {end_req.value, end_req.idx};
        unique case (r_state)
            rlh_pkg::S_RUN: begin
                stall_int = 1'b0;
                rd_req.en = end_req.valid;
            end
            rlh_pkg::S_FINAL: begin
                // The run that the last word closes, including that word's bit.
                rd_req.en   = final_req.valid;
                rd_req.addr = {final_req.value, final_req.idx};
            end
            rlh_pkg::S_WAIT: begin
                rd_req.en = 1'b0;
            end
            rlh_pkg::S_DUMP: begin
                rd_req.en   = dump_issue;
                rd_req.incr = 1'b0;
                rd_req.addr = {r_dump_val, r_dump_idx};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rlh_pkg::S_RUN;
            r_k_cfg     <= rlh_pkg::K_RESET;
            r_dump_more <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_k_cfg <= i_cfg_data;
            end
            if (r_state == rlh_pkg::S_WAIT) begin
                r_dump_more <= 1'b1;
            end else if (dump_issue && !r_dump_val && dump_at_end) begin
                r_dump_more <= 1'b0;
            end
            if (dump_issue) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rlh_pkg::S_WAIT) begin
            r_dump_val <= 1'b1;
            r_dump_idx <= '0;
        end else if (dump_issue) begin
            if (dump_at_end) begin
                r_dump_val <= 1'b0;
                r_dump_idx <= '0;
            end else begin
                r_dump_idx <= r_dump_idx + 1'b1;
            end
        end
        if (dump_issue) begin
            r_out_value <= r_dump_val;
            r_out_len   <= rlh_pkg::LEN_OUT_W'(dump_len);
            r_out_last  <= !r_dump_val && dump_at_end;
        end
    end

    assign o_stall      = stall_int;
    assign o_valid      = r_out_valid;
    assign o_run_value  = r_out_value;
    assign o_run_length = r_out_len;
    assign o_last_entry = r_out_last;

    `RLH_ASSERT_IMPL(a_out_only_stalled, o_valid, o_stall, "word sent while input is open")
    `RLH_ASSERT(a_last_closes, (done |=> !o_valid), "word sent after the last entry")

endmodule

### tb/sv/rlh_dump_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlh_dump_checker
// Watches the bit stream, the configuration port and the histogram dump of
// the run-length histogram core. Keeps its own run counters and histograms,
// queues the words each end of sequence should produce and compares every
// dumped word field by field with the oldest one in the queue.
// ----------------------------------------------------------------------------
module rlh_dump_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rlh_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    input  logic                          i_in_stall,
    input  logic                          i_bit_in,
    input  logic                          i_end_of_sequence,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_run_value,
    input  logic [rlh_pkg::LEN_OUT_W-1:0] i_run_length,
    input  logic [rlh_pkg::CNT_W-1:0]     i_run_count,
    input  logic                          i_last_entry,
    output int                            o_mismatches,
    output int                            o_outstanding
);

    typedef struct packed {
        logic                          value;
        logic [rlh_pkg::LEN_OUT_W-1:0] length;
        logic [rlh_pkg::CNT_W-1:0]     count;
        logic                          last;
    } t_hist_word;

    t_hist_word                expected_words[$];
    logic [rlh_pkg::CNT_W-1:0] ones_runs  [rlh_pkg::MAX_RUN_LEN];
    logic [rlh_pkg::CNT_W-1:0] zeros_runs [rlh_pkg::MAX_RUN_LEN];
    logic [rlh_pkg::CFG_W-1:0] k_reg      = rlh_pkg::K_RESET;
    int unsigned               run_len    = 0;
    logic                      run_bit    = 1'b0;
    logic                      mid_stream = 1'b0;
    int                        mismatch_count = 0;
    int                        pending_count  = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = pending_count;

    // A setting of zero counts runs of length one; anything above
    // MAX_RUN_LEN is clipped to it.
    function automatic int unsigned counted_k(input logic [rlh_pkg::CFG_W-1:0] cfg);
        if (cfg == '0) begin
            return 1;
        end
        if (int'(cfg) > rlh_pkg::MAX_RUN_LEN) begin
            return rlh_pkg::MAX_RUN_LEN;
        end
        return int'(cfg);
    endfunction

    task automatic clear_history();
        for (int i = 0; i < rlh_pkg::MAX_RUN_LEN; i++) begin
            ones_runs[i]  = '0;
            zeros_runs[i] = '0;
        end
        run_len    = 0;
        run_bit    = 1'b0;
        mid_stream = 1'b0;
    endtask

    task automatic close_run(input logic value, input int unsigned len, input int unsigned k);
        if (len >= 1 && len <= k) begin
            if (value) begin
                if (ones_runs[len-1] != rlh_pkg::CNT_MAX) begin
                    ones_runs[len-1] += 1'b1;
                end
            end else begin
                if (zeros_runs[len-1] != rlh_pkg::CNT_MAX) begin
                    zeros_runs[len-1] += 1'b1;
                end
            end
        end
    endtask

    task automatic take_bit(input logic value, input logic eos);
        int unsigned k;
        t_hist_word  word;
        k = counted_k(k_reg);
        if (!mid_stream) begin
            run_bit    = value;
            run_len    = 1;
            mid_stream = 1'b1;
        end else if (value == run_bit) begin
            // The counter stops one past k, so an over-long run never counts.
            if (run_len < k + 1) begin
                run_len++;
            end else begin
                run_len = k + 1;
            end
        end else begin
            close_run(run_bit, run_len, k);
            run_bit = value;
            run_len = 1;
        end
        if (eos) begin
            close_run(run_bit, run_len, k);
            for (int v = 0; v < 2; v++) begin
                for (int i = 0; i < k; i++) begin
                    word.value  = (v == 0);
                    word.length = rlh_pkg::LEN_OUT_W'(i + 1);
                    word.count  = (v == 0) ? ones_runs[i] : zeros_runs[i];
                    word.last   = (v == 1) && (i + 1 == k);
                    expected_words.push_back(word);
                end
            end
            clear_history();
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_hist_word want;
        if (!i_rst_n) begin
            clear_history();
            k_reg = rlh_pkg::K_RESET;
            expected_words.delete();
        end else begin
            if (i_valid && !i_in_stall) begin
                take_bit(i_bit_in, i_end_of_sequence);
            end
            // A write takes effect for words after this edge.
            if (i_cfg_we) begin
                k_reg = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("histogram word with none expected: value %0d length %0d count %0d",
                           i_run_value, i_run_length, i_run_count);
                    mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_run_value !== want.value) begin
                        $error("run_value: expected %0d, got %0d", want.value, i_run_value);
                        mismatch_count++;
                    end
                    if (i_run_length !== want.length) begin
                        $error("run_length: expected %0d, got %0d", want.length, i_run_length);
                        mismatch_count++;
                    end
                    if (i_run_count !== want.count) begin
                        $error("run_count: expected %0d, got %0d", want.count, i_run_count);
                        mismatch_count++;
                    end
                    if (i_last_entry !== want.last) begin
                        $error("last_entry: expected %0d, got %0d", want.last, i_last_entry);
                        mismatch_count++;
                    end
                end
            end
        end
        pending_count = expected_words.size();
    end

endmodule

### tb/sv/tb_run_length_histogram_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_run_length_histogram_core
// Drives bit streams and settings of the longest counted run into the core.
// A short directed part covers one-bit sequences, settings of zero, the
// MAX_RUN_LEN and above it, over-long runs and settings changed in the
// middle of a stream. Random streams, mostly of runs near k, follow, with bursty
// input and a stalling receiver. The checker judges every dumped word.
// ----------------------------------------------------------------------------
module tb_run_length_histogram_core;

    localparam int STREAM_ITEMS  = 480;
    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int CFG_PAUSE     = 4;

    logic                          i_clk             = 1'b0;
    logic                          i_rst_n           = 1'b0;
    logic                          i_cfg_we          = 1'b0;
    logic [rlh_pkg::CFG_W-1:0]     i_cfg_data        = '0;
    logic                          i_valid           = 1'b0;
    logic                          i_bit_in          = 1'b0;
    logic                          i_end_of_sequence = 1'b0;
    logic                          i_stall           = 1'b0;
    logic                          o_stall;
    logic                          o_valid;
    logic                          o_run_value;
    logic [rlh_pkg::LEN_OUT_W-1:0] o_run_length;
    logic [rlh_pkg::CNT_W-1:0]     o_run_count;
    logic                          o_last_entry;

    int   mismatches;
    int   outstanding;
    bit   tx_gaps_on   = 1'b0;
    bit   rx_stalls_on = 1'b0;
    int   burst_left   = 0;
    int   stall_hold   = 0;
    int   idle_cycles  = 0;
    int   bits_sent    = 0;
    int   k_now        = 10;
    logic stream_bits[$];

    run_length_histogram_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_bit_in          (i_bit_in),
        .i_end_of_sequence (i_end_of_sequence),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_run_value       (o_run_value),
        .o_run_length      (o_run_length),
        .o_run_count       (o_run_count),
        .o_last_entry      (o_last_entry)
    );

    rlh_dump_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .i_in_stall        (o_stall),
        .i_bit_in          (i_bit_in),
        .i_end_of_sequence (i_end_of_sequence),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_run_value       (o_run_value),
        .i_run_length      (o_run_length),
        .i_run_count       (o_run_count),
        .i_last_entry      (o_last_entry),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver alternates between free and stalled stretches of random length.
    always @(posedge i_clk) begin
        if (!rx_stalls_on) begin
            i_stall <= 1'b0;
            stall_hold = 0;
        end else if (stall_hold == 0) begin
            i_stall <= ~i_stall;
            stall_hold = i_stall ? $urandom_range(0, 7) : $urandom_range(0, 4);
        end else begin
            stall_hold--;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_bit(input logic value, input logic eos);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = tx_gaps_on ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid           <= 1'b1;
        i_bit_in          <= value;
        i_end_of_sequence <= eos;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
        bits_sent++;
    endtask

    // Waits until every dumped word has been taken, then lets any run update
    // still in flight finish before the setting changes.
    task automatic write_k(input logic [rlh_pkg::CFG_W-1:0] value);
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (CFG_PAUSE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (value == '0) begin
            k_now = 1;
        end else if (int'(value) > rlh_pkg::MAX_RUN_LEN) begin
            k_now = rlh_pkg::MAX_RUN_LEN;
        end else begin
            k_now = int'(value);
        end
    endtask

    // Sends n bits, least significant first, marking the last one if asked.
    task automatic send_pattern(input logic [31:0] pattern, input int n, input logic close);
        for (int i = 0; i < n; i++) begin
            send_bit(pattern[i], close && (i == n - 1));
        end
    endtask

    initial begin
        int   n;
        int   split_at;
        int   rl;
        logic value;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // One-bit sequences of each value under the reset setting.
        send_pattern(32'b1, 1, 1'b1);
        send_pattern(32'b0, 1, 1'b1);
        // A setting of zero counts only runs of one.
        write_k('0);
        send_pattern(32'b0100, 4, 1'b1);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        // Settings at and above MAX_RUN_LEN.
        write_k(5'd31);
        send_pattern(32'b011, 3, 1'b1);
        write_k(5'd24);
        send_pattern(32'b0110, 4, 1'b1);
        // Changing k in the middle of a stream: a run saturated under the old k is judged against the new one.
        write_k(5'd3);
        send_pattern(32'b11111, 5, 1'b0);
        write_k(5'd2);
        send_pattern(32'b01, 2, 1'b1);
        write_k(5'd5);
        send_pattern(32'b00, 2, 1'b0);
        write_k(5'd1);
        send_pattern(32'b1, 1, 1'b1);

        while (bits_sent < STREAM_ITEMS) begin
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 7) == 0) begin
                    write_k($urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(25, 31)));
                end else begin
                    write_k(5'($urandom_range(1, rlh_pkg::MAX_RUN_LEN)));
                end
            end

            stream_bits.delete();
            n = (k_now > 12) ? $urandom_range(20, 70) : $urandom_range(1, 30);
            if ($urandom_range(0, 4) == 0) begin
                repeat (n) stream_bits.push_back(1'($urandom_range(0, 1)));
            end else begin
                // Runs of lengths around k, so that both counted and dropped runs occur.
                value = 1'($urandom_range(0, 1));
                while (stream_bits.size() < n) begin
                    rl = $urandom_range(1, k_now + 2);
                    repeat (rl) begin
                        if (stream_bits.size() < n) begin
                            stream_bits.push_back(value);
                        end
                    end
                    value = ~value;
                end
            end

            split_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1) : -1;
            for (int i = 0; i < n; i++) begin
                if (i == split_at) begin
                    write_k(5'($urandom_range(0, 31)));
                end
                send_bit(stream_bits[i], i == n - 1);
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/rlh_pkg.sv
hw/rtl/rlh_ram.sv
hw/rtl/rlh_tracker.sv
hw/rtl/rlh_hist.sv
hw/rtl/run_length_histogram_core.sv
tb/sv/rlh_dump_checker.sv
tb/sv/tb_run_length_histogram_core.sv
